### hdl/bbp_pkg.sv
// bbp_pkg: shared constants, codes and types of the bidirectional bit packer
// no dependencies; compiled first
package bbp_pkg;

  localparam int MAX_FIELD_BITS = 16;
  localparam int DATA_W         = 16;
  localparam int CNT_W          = 5;
  localparam int ACC_W          = 24;
  localparam int BYTE_W         = 8;
  localparam int VB_W           = 4;
  localparam int TOT_W          = 32;
  localparam int FILL_W         = 3;
  localparam int EFF_MAX        = (MAX_FIELD_BITS < DATA_W) ? MAX_FIELD_BITS : DATA_W;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  typedef enum logic {
    ORDER_FWD = 1'b0,
    ORDER_REV = 1'b1
  } order_t;

  // up to two bytes produced by one accepted word
  typedef struct packed {
    logic [1:0]        cnt;
    logic [BYTE_W-1:0] byte0;
    logic [BYTE_W-1:0] byte1;
    logic [VB_W-1:0]   vbits0;
    logic              last0;
  } bbp_pair_t;

endpackage

### hdl/bbp_in_if.sv
// bbp_in_if: valid/ready channel carrying one packer command word
// depends on bbp_pkg
interface bbp_in_if import bbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [DATA_W-1:0] data_bits;
  logic [CNT_W-1:0]  bit_count;

  modport source (output valid, command, data_bits, bit_count, input ready);
  modport sink   (input valid, command, data_bits, bit_count, output ready);
endinterface

### hdl/bbp_out_if.sv
// bbp_out_if: valid/ready channel carrying one packed byte and its status
// depends on bbp_pkg
interface bbp_out_if import bbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic [VB_W-1:0]   valid_bits;
  logic              last;
  logic [TOT_W-1:0]  total_bits;

  modport source (output valid, out_byte, valid_bits, last, total_bits, input ready);
  modport sink   (input valid, out_byte, valid_bits, last, total_bits, output ready);
endinterface

### hdl/bidirectional_bit_packer_unit.sv
// bidirectional_bit_packer_unit: top level of the bidirectional bit packer
// output: a byte is offered on the output in the cycle after its word is taken
// throughput: one byte per cycle on the output port while out_ready is high; a word that
// completes two bytes holds off the next word until its first byte is taken
// reset: synchronous active-low rst_n clears bit order, accumulator, fill, buffered byte count and total
// depends on bbp_pkg, bbp_in_if, bbp_out_if, bbp_packer, bbp_out_buf
module bidirectional_bit_packer_unit import bbp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  bbp_in_if.sink     in_ch,
  bbp_out_if.source  out_ch
);

  logic      can_take;
  logic      accept;
  bbp_pair_t pair;

  assign in_ch.ready = can_take;
  assign accept      = in_ch.valid && can_take;

  bbp_packer u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .command   (in_ch.command),
    .data_bits (in_ch.data_bits),
    .bit_count (in_ch.bit_count),
    .pair      (pair)
  );

  bbp_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .pair       (pair),
    .can_take   (can_take),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_byte   (out_ch.out_byte),
    .valid_bits (out_ch.valid_bits),
    .last       (out_ch.last),
    .total_bits (out_ch.total_bits)
  );

endmodule

### hdl/bbp_packer.sv
// bbp_packer: bit accumulator, fill count and bit order register; turns one
// accepted word into zero to two bytes. depends on bbp_pkg
module bbp_packer import bbp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              accept,
  input  logic              command,
  input  logic [DATA_W-1:0] data_bits,
  input  logic [CNT_W-1:0]  bit_count,
  output bbp_pair_t         pair
);

  order_t            order_r, order_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  logic [CNT_W-1:0]  n_eff;
  logic [DATA_W:0]   ones;
  logic [ACC_W-1:0]  wide;
  logic [CNT_W-1:0]  fwd_sh;
  logic [CNT_W-1:0]  sum;
  logic [ACC_W-1:0]  acc_fwd, acc_rev;
  logic              one_b, two_b;

  always_comb begin
    n_eff   = (bit_count > CNT_W'(EFF_MAX)) ? CNT_W'(EFF_MAX) : bit_count;
    ones    = ~({(DATA_W+1){1'b1}} << n_eff);
    wide    = {{(ACC_W-DATA_W){1'b0}}, data_bits & ones[DATA_W-1:0]};
    fwd_sh  = CNT_W'(ACC_W) - {{(CNT_W-FILL_W){1'b0}}, fill_r} - n_eff;
    sum     = {{(CNT_W-FILL_W){1'b0}}, fill_r} + n_eff;
    acc_fwd = acc_r | (wide << fwd_sh);
    acc_rev = acc_r | (wide << fill_r);
    two_b   = sum >= CNT_W'(2*BYTE_W);
    one_b   = sum >= CNT_W'(BYTE_W);

    order_nxt    = order_r;
    acc_nxt      = acc_r;
    fill_nxt     = fill_r;
    pair         = '0;
    pair.vbits0  = VB_W'(BYTE_W);

    if (cfg_we) begin
      order_nxt = order_t'(cfg_wdata);
      acc_nxt   = '0;
      fill_nxt  = '0;
    end else if (accept) begin
      if (cmd_t'(command) == CMD_FLUSH) begin
        if (fill_r != '0) begin
          pair.cnt    = 2'd1;
          pair.byte0  = (order_r == ORDER_FWD) ? acc_r[ACC_W-1 -: BYTE_W]
                                               : acc_r[BYTE_W-1:0];
          pair.vbits0 = {{(VB_W-FILL_W){1'b0}}, fill_r};
          pair.last0  = 1'b1;
        end
        acc_nxt  = '0;
        fill_nxt = '0;
      end else if (n_eff != '0) begin
        pair.cnt = two_b ? 2'd2 : (one_b ? 2'd1 : 2'd0);
        fill_nxt = sum[FILL_W-1:0];
        if (order_r == ORDER_FWD) begin
          pair.byte0 = acc_fwd[ACC_W-1 -: BYTE_W];
          pair.byte1 = acc_fwd[ACC_W-BYTE_W-1 -: BYTE_W];
          acc_nxt    = two_b ? (acc_fwd << (2*BYTE_W))
                             : (one_b ? (acc_fwd << BYTE_W) : acc_fwd);
        end else begin
          pair.byte0 = acc_rev[BYTE_W-1:0];
          pair.byte1 = acc_rev[2*BYTE_W-1 -: BYTE_W];
          acc_nxt    = two_b ? (acc_rev >> (2*BYTE_W))
                             : (one_b ? (acc_rev >> BYTE_W) : acc_rev);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_FWD;
      acc_r   <= '0;
      fill_r  <= '0;
    end else begin
      order_r <= order_nxt;
      acc_r   <= acc_nxt;
      fill_r  <= fill_nxt;
    end
  end

endmodule

### hdl/bbp_out_buf.sv
// bbp_out_buf: two-entry byte holding register, one byte a cycle to the
// output while out_ready is high, and the saturating emitted bit total. depends on bbp_pkg
module bbp_out_buf import bbp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bbp_pair_t         pair,
  output logic              can_take,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic [VB_W-1:0]   valid_bits,
  output logic              last,
  output logic [TOT_W-1:0]  total_bits
);

  logic [1:0]        cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] b0_r, b0_nxt, b1_r, b1_nxt;
  logic [VB_W-1:0]   v0_r, v0_nxt;
  logic              last0_r, last0_nxt;
  logic [TOT_W-1:0]  tot_r, tot_nxt;
  logic [TOT_W:0]    tot_sum;
  logic              pop;

  assign out_valid  = cnt_r != 2'd0;
  assign pop        = out_valid && out_ready;
  assign can_take   = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign out_byte   = b0_r;
  assign valid_bits = v0_r;
  assign last       = last0_r;
  assign tot_sum    = {1'b0, tot_r} + {{(TOT_W+1-VB_W){1'b0}}, v0_r};
  assign total_bits = tot_sum[TOT_W] ? {TOT_W{1'b1}} : tot_sum[TOT_W-1:0];

  always_comb begin
    cnt_nxt   = cnt_r;
    b0_nxt    = b0_r;
    b1_nxt    = b1_r;
    v0_nxt    = v0_r;
    last0_nxt = last0_r;
    tot_nxt   = pop ? total_bits : tot_r;
    if (push) begin
      cnt_nxt   = pair.cnt;
      b0_nxt    = pair.byte0;
      b1_nxt    = pair.byte1;
      v0_nxt    = pair.vbits0;
      last0_nxt = pair.last0;
    end else if (pop) begin
      cnt_nxt   = cnt_r - 2'd1;
      b0_nxt    = b1_r;
      v0_nxt    = VB_W'(BYTE_W);
      last0_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      tot_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      tot_r <= tot_nxt;
    end
    b0_r    <= b0_nxt;
    b1_r    <= b1_nxt;
    v0_r    <= v0_nxt;
    last0_r <= last0_nxt;
  end

endmodule
